// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the shortest-path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, except while reset is asserted.
`define DSP_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define DSP_ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/dsp_pkg.sv =====
// Package with the types, constants and widths of the shortest-path block.
package dsp_pkg;

    // Fixed field widths of the two channels and the configuration register.
    localparam int ROW_BITS        = 5;
    localparam int WEIGHT_IN_BITS  = 16;
    localparam int VERTEX_BITS     = 5;
    localparam int DIST_BITS       = 24;
    localparam int COUNT_CFG_BITS  = 6;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_WEIGHT_BITS  = 16;

    // Distance of a vertex that cannot be reached, and the result count limit.
    localparam logic [DIST_BITS-1:0]      UNREACHED    = 24'd10000000;
    localparam int                        RESULT_LIMIT = 32;
    localparam logic [COUNT_CFG_BITS-1:0] COUNT_RESET  = 6'd32;

    // Sequencer states.
    typedef enum logic [3:0] {
        SQ_LOAD,
        SQ_INIT,
        SQ_SCAN,
        SQ_PICK,
        SQ_MARK,
        SQ_RELAX,
        SQ_EMIT_RD,
        SQ_EMIT_LOAD,
        SQ_EMIT_WAIT
    } st_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic adj_wr;
        logic visit_clr;
        logic idx_clr;
        logic idx_inc;
        logic round_clr;
        logic round_inc;
        logic init_wr;
        logic scan_issue;
        logic relax_issue;
        logic best_clr;
        logic mark_visit;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;
        logic round_last;
        logic single_vertex;
    } status_t;

endpackage

// ===== rtl/dsp_in_if.sv =====
// Channel interface for matrix entry transactions.
interface dsp_in_if;
    import dsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ROW_BITS-1:0]       row;
    logic [ROW_BITS-1:0]       col;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic                      last;

    modport source (output valid, output row, output col, output weight, output last,
                    input ready);
    modport sink   (input valid, input row, input col, input weight, input last,
                    output ready);
endinterface

// ===== rtl/dsp_out_if.sv =====
// Channel interface for per-vertex distance result transactions.
interface dsp_out_if;
    import dsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VERTEX_BITS-1:0] vertex;
    logic [DIST_BITS-1:0]   distance;
    logic                   final_res;

    modport source (output valid, output vertex, output distance, output final_res,
                    input ready);
    modport sink   (input valid, input vertex, input distance, input final_res,
                    output ready);
endinterface

// ===== rtl/dense_shortest_path.sv =====
// Top level of the dense-matrix single-source shortest-path block.
// Matrix entries are taken one per cycle while the block is loading. The entry marked last
// starts the search from vertex 0 over n vertices (the configured count, at least one and
// at most the built size or 32). The search then presets the distances and runs n - 1
// rounds, each a scan for the closest unvisited vertex and a relaxation pass over its row;
// each pass visits every vertex once through the single read port of the distance memory.
// Results follow in vertex order; each is read, loaded into the result register and then
// offered until the sink is ready. No new entry is taken from the last entry until the
// final result transaction has completed.
`include "assert_macros.svh"

module dense_shortest_path #(
    parameter int MAX_VERTICES = dsp_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [dsp_pkg::COUNT_CFG_BITS-1:0] cfg_wr_data,
    dsp_in_if.sink                             matrix,
    dsp_out_if.source                          result
);
    import dsp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    dsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (matrix.valid),
        .in_last   (matrix.last),
        .in_ready  (matrix.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    dsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .row         (matrix.row),
        .col         (matrix.col),
        .weight      (matrix.weight),
        .cmd         (cmd),
        .status      (status),
        .vertex      (result.vertex),
        .distance    (result.distance),
        .final_res   (result.final_res)
    );

    // Loading and emission never overlap.
    `DSP_ASSERT_NEVER(a_load_emit_excl, clk, rst_n, matrix.ready && result.valid, "input ready while a result is offered")

    // The last entry closes the input until the search has run.
    `DSP_ASSERT(a_last_closes_input, clk, rst_n, (matrix.valid && matrix.ready && matrix.last) |=> !matrix.ready, "input still ready after last entry")

    // After the final result transaction the block loads again.
    `DSP_ASSERT(a_final_reopens, clk, rst_n, (result.valid && result.ready && result.final_res) |=> matrix.ready, "input not ready after final result")

    // A result other than the final one is followed by a gap while the next is read.
    `DSP_ASSERT(a_result_gap, clk, rst_n, (result.valid && result.ready && !result.final_res) |=> !result.valid && !matrix.ready, "unexpected state after a result")

endmodule

// ===== rtl/dsp_ctrl.sv =====
// Controller state machine that sequences loading, the search rounds and emission.
module dsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  dsp_pkg::status_t status,
    output dsp_pkg::cmd_t    cmd
);
    import dsp_pkg::*;

    st_t state_reg;
    st_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = SQ_INIT;
                end
            end
            SQ_INIT:
            begin
                if (status.idx_last)
                begin
                    state_next = status.single_vertex ? SQ_EMIT_RD : SQ_SCAN;
                end
            end
            SQ_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = SQ_PICK;
                end
            end
            SQ_PICK:
            begin
                state_next = SQ_MARK;
            end
            SQ_MARK:
            begin
                state_next = SQ_RELAX;
            end
            SQ_RELAX:
            begin
                if (status.idx_last)
                begin
                    state_next = status.round_last ? SQ_EMIT_RD : SQ_SCAN;
                end
            end
            SQ_EMIT_RD:
            begin
                state_next = SQ_EMIT_LOAD;
            end
            SQ_EMIT_LOAD:
            begin
                state_next = SQ_EMIT_WAIT;
            end
            SQ_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = status.idx_last ? SQ_LOAD : SQ_EMIT_RD;
                end
            end
            default:
            begin
                state_next = SQ_LOAD;
            end
        endcase
    end

    // Command and handshake outputs.
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            SQ_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.adj_wr = 1'b1;
                    if (in_last)
                    begin
                        cmd.visit_clr = 1'b1;
                        cmd.idx_clr   = 1'b1;
                    end
                end
            end
            SQ_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr   = 1'b1;
                    cmd.round_clr = 1'b1;
                    cmd.best_clr  = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            SQ_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            SQ_PICK:
            begin
                cmd = '0;
            end
            SQ_MARK:
            begin
                cmd.mark_visit = 1'b1;
            end
            SQ_RELAX:
            begin
                cmd.relax_issue = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr   = 1'b1;
                    cmd.round_inc = 1'b1;
                    cmd.best_clr  = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            SQ_EMIT_RD:
            begin
                cmd = '0;
            end
            SQ_EMIT_LOAD:
            begin
                cmd.out_load = 1'b1;
            end
            SQ_EMIT_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/dsp_datapath.sv =====
// Datapath: matrix and distance memories, visited flags, counters and compare logic.
module dsp_datapath #(
    parameter int MAX_VERTICES = dsp_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dsp_pkg::COUNT_CFG_BITS-1:0]  cfg_wr_data,
    input  logic [dsp_pkg::ROW_BITS-1:0]        row,
    input  logic [dsp_pkg::ROW_BITS-1:0]        col,
    input  logic [dsp_pkg::WEIGHT_IN_BITS-1:0]  weight,
    input  dsp_pkg::cmd_t                       cmd,
    output dsp_pkg::status_t                    status,
    output logic [dsp_pkg::VERTEX_BITS-1:0]     vertex,
    output logic [dsp_pkg::DIST_BITS-1:0]       distance,
    output logic                                final_res
);
    import dsp_pkg::*;

    localparam int VB    = $clog2(MAX_VERTICES);
    localparam int CB    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCAP  = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;

    // Memories.
    logic [WEIGHT_BITS-1:0] adj_mem  [DEPTH];
    logic [DIST_BITS-1:0]   dist_mem [MAX_VERTICES];

    logic [COUNT_CFG_BITS-1:0] count_reg;
    logic [CB-1:0]             n_used;
    logic [VB-1:0]             idx_reg;
    logic [VB-1:0]             round_reg;
    logic [MAX_VERTICES-1:0]   visited_reg;

    logic                      p_scan_reg;
    logic                      p_relax_reg;
    logic [VB-1:0]             p_idx_reg;
    logic                      p_vis_reg;
    logic [DIST_BITS-1:0]      dist_rd_reg;
    logic [WEIGHT_BITS-1:0]    adj_rd_reg;

    logic                      found_reg;
    logic [VB-1:0]             best_idx_reg;
    logic [DIST_BITS-1:0]      best_dist_reg;

    logic [VERTEX_BITS-1:0]    vertex_reg;
    logic [DIST_BITS-1:0]      distance_reg;
    logic                      final_reg;

    logic [31:0]               row_w;
    logic [31:0]               col_w;
    logic [31:0]               weight_w;
    logic [31:0]               idx_w;
    logic                      entry_ok;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [DIST_BITS:0]        cand;
    logic                      scan_better;
    logic                      relax_wr;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    // Number of vertices in use: zero counts as one, capped at the built size and the result limit.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_used = CB'(1);
        end
        else if (int'(count_reg) > NCAP)
        begin
            n_used = CB'(NCAP);
        end
        else
        begin
            n_used = CB'(count_reg);
        end
    end

    assign status.idx_last      = (CB'(idx_reg) == n_used - CB'(1));
    assign status.round_last    = (CB'(round_reg) == n_used - CB'(2));
    assign status.single_vertex = (n_used == CB'(1));

    // Index and round counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + VB'(1);
            end
            if (cmd.round_clr)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_inc)
            begin
                round_reg <= round_reg + VB'(1);
            end
        end
    end

    // Matrix entry write: out-of-range rows and columns are dropped.
    assign row_w    = 32'(row);
    assign col_w    = 32'(col);
    assign weight_w = 32'(weight);
    assign entry_ok = (int'(row) < MAX_VERTICES) && (int'(col) < MAX_VERTICES);
    assign wr_addr  = AW'(row_w[VB-1:0]) * AW'(MAX_VERTICES) + AW'(col_w[VB-1:0]);
    assign rd_addr  = AW'(best_idx_reg) * AW'(MAX_VERTICES) + AW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.adj_wr && entry_ok)
        begin
            adj_mem[wr_addr] <= weight_w[WEIGHT_BITS-1:0];
        end
        adj_rd_reg <= adj_mem[rd_addr];
    end

    // Relaxation candidate from the picked vertex.
    assign cand     = {1'b0, best_dist_reg} + (DIST_BITS+1)'(adj_rd_reg);
    assign relax_wr = p_relax_reg && (adj_rd_reg != '0) && !p_vis_reg
                      && (cand < {1'b0, dist_rd_reg});

    // Distance memory: one write, one registered read at the running index.
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            dist_mem[idx_reg] <= (idx_reg == '0) ? '0 : UNREACHED;
        end
        else if (relax_wr)
        begin
            dist_mem[p_idx_reg] <= cand[DIST_BITS-1:0];
        end
        dist_rd_reg <= dist_mem[idx_reg];
    end

    // Pipeline tags that travel with each memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_scan_reg  <= 1'b0;
            p_relax_reg <= 1'b0;
        end
        else
        begin
            p_scan_reg  <= cmd.scan_issue;
            p_relax_reg <= cmd.relax_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg <= idx_reg;
        p_vis_reg <= visited_reg[idx_reg];
    end

    // Visited flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
        end
        else if (cmd.visit_clr)
        begin
            visited_reg <= '0;
        end
        else if (cmd.mark_visit)
        begin
            visited_reg[best_idx_reg] <= 1'b1;
        end
    end

    // Minimum search; strict compare keeps the lowest index on ties.
    assign scan_better = p_scan_reg && !p_vis_reg
                         && (!found_reg || (dist_rd_reg < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.best_clr)
        begin
            found_reg <= 1'b0;
        end
        else if (scan_better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_better)
        begin
            best_idx_reg  <= p_idx_reg;
            best_dist_reg <= dist_rd_reg;
        end
    end

    // Result register.
    assign idx_w = 32'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            vertex_reg   <= idx_w[VERTEX_BITS-1:0];
            distance_reg <= dist_rd_reg;
            final_reg    <= status.idx_last;
        end
    end

    assign vertex    = vertex_reg;
    assign distance  = distance_reg;
    assign final_res = final_reg;

endmodule
